// ===== rtl/core/sc2a_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, key codes and translation tables for the scancode-to-ASCII FIFO.
// Depends on nothing; every other file in rtl/core imports it.
package sc2a_pkg;

   // Default character store depth.
   localparam int FIFO_DEPTH_DEF = 256;

   // Widths fixed by the request and response fields.
   localparam int SCAN_W = 8;
   localparam int CHAR_W = 7;

   // Request kinds.
   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Set-1 codes with a special meaning.
   localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [SCAN_W-1:0] SC_CAPS_MAKE    = 8'h3A;

   // Lower-case letter bounds and the bit that separates the two cases.
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
   localparam int                CASE_BIT   = 5;

   // Tables cover the 64 codes below 0x40; codes from 0x3A up give zero.
   localparam int TABLE_IDX_W = 6;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [0:63] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [CHAR_W-1:0] UPPER_MAP [0:63] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // Character produced by the translator for one scancode request.
   typedef struct packed {
      logic              push;
      logic [CHAR_W-1:0] ch;
   } push_type;

endpackage

// ===== rtl/core/sc2a_xlate.sv =====
`timescale 1ns / 1ps
// Scancode translator: shift and caps flag registers plus the table lookup.
// Depends on sc2a_pkg for key codes, tables and the push_type struct.
module sc2a_xlate (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         scan_en,
   input  logic [sc2a_pkg::SCAN_W-1:0]  scan_code,
   output sc2a_pkg::push_type           push_out
);
   import sc2a_pkg::*;

   logic                   shift_ff, shift_in;
   logic                   caps_ff, caps_in;
   logic [TABLE_IDX_W-1:0] idx;
   logic [CHAR_W-1:0]      looked_up;
   logic                   is_lower;
   logic                   special;

   assign idx = scan_code[TABLE_IDX_W-1:0];

   // Flag updates and detection of the codes that only change flags.
   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      special  = 1'b1;
      case (scan_code)
         SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_in = 1'b1;
         SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_in = 1'b0;
         SC_CAPS_MAKE:                     caps_in  = ~caps_ff;
         default:                          special  = 1'b0;
      endcase
      if (!scan_en) begin
         shift_in = shift_ff;
         caps_in  = caps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

   // Table lookup and caps fix-up; break codes and codes from 0x40 up give nothing.
   always_comb begin
      looked_up = shift_ff ? UPPER_MAP[idx] : PLAIN_MAP[idx];
      is_lower  = (looked_up >= CH_LOWER_A) && (looked_up <= CH_LOWER_Z);
      push_out.ch = looked_up;
      if (is_lower && (caps_ff ^ shift_ff)) begin
         push_out.ch[CASE_BIT] = 1'b0;
      end
      push_out.push = scan_en && !special
                      && (scan_code[SCAN_W-1:TABLE_IDX_W] == '0)
                      && (looked_up != '0);
   end

endmodule

// ===== rtl/core/sc2a_mem.sv =====
`timescale 1ns / 1ps
// Character store: one write port and one read port with registered read data.
// Depends on sc2a_pkg for the character width.
module sc2a_mem #(
   parameter int DEPTH = sc2a_pkg::FIFO_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [sc2a_pkg::CHAR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [sc2a_pkg::CHAR_W-1:0] rd_data
);
   import sc2a_pkg::*;

   logic [CHAR_W-1:0] store [0:DEPTH-1];
   logic [CHAR_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/scancode_to_ascii_fifo_unit.sv =====
`timescale 1ns / 1ps
// Scancode-to-ASCII translator with a character FIFO, top level.
// The response is registered and appears in the cycle after the request is taken; one request
// is taken every cycle unless the response register is full and stalled by the response side.
// Synchronous reset clears the shift and caps flags, both pointers and the response
// register at once; the character store has no reset and needs no clearing pass.
// Depends on sc2a_pkg, sc2a_xlate and sc2a_mem.
module scancode_to_ascii_fifo_unit #(
   parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [sc2a_pkg::SCAN_W-1:0]  req_scan_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sc2a_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic                         rsp_char_valid,
   output logic                         rsp_input_pending
);
   import sc2a_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

   logic          accept;
   push_type      push;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_next, rd_ptr_next;
   logic          do_push, do_pop;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          char_valid_ff, char_valid_in;
   logic          pending_ff, pending_in;
   logic [CHAR_W-1:0] rd_data;

   // A request enters whenever the response register is empty or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   sc2a_xlate u_xlate (
      .clock     (clock),
      .reset     (reset),
      .scan_en   (accept && (req_type == REQ_SCAN)),
      .scan_code (req_scan_code),
      .push_out  (push)
   );

   // Ring pointers; one slot stays empty so equal pointers mean empty.
   always_comb begin
      wr_ptr_next = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_next = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      do_push     = push.push && (wr_ptr_next != rd_ptr_ff);
      do_pop      = accept && (req_type == REQ_READ) && (wr_ptr_ff != rd_ptr_ff);
      wr_ptr_in   = do_push ? wr_ptr_next : wr_ptr_ff;
      rd_ptr_in   = do_pop  ? rd_ptr_next : rd_ptr_ff;
   end

   // A pop reads the entry written no later than the previous edge, so the
   // store never sees a read and write of the same slot in one cycle.
   sc2a_mem #(
      .DEPTH (FIFO_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push.ch),
      .rd_en   (do_pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Response register contents.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      char_valid_in = char_valid_ff;
      pending_in    = pending_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         char_valid_in = do_pop;
         pending_in    = (wr_ptr_in != rd_ptr_in);
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         char_valid_ff <= 1'b0;
         pending_ff    <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         char_valid_ff <= char_valid_in;
         pending_ff    <= pending_in;
      end
   end

   // The popped character comes straight from the store's read register.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_valid    = char_valid_ff;
   assign rsp_char_out      = char_valid_ff ? rd_data : '0;
   assign rsp_input_pending = pending_ff;

endmodule

// ===== dv/scancode_to_ascii_fifo_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the scancode-to-ASCII FIFO unit: watches both channels, predicts each response
// and compares it field by field. Depends on sc2a_pkg for widths and special key codes.
module scancode_to_ascii_fifo_unit_checker #(
   parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_type,
   input  logic [sc2a_pkg::SCAN_W-1:0]  req_scan_code,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [sc2a_pkg::CHAR_W-1:0]  rsp_char_out,
   input  logic                         rsp_char_valid,
   input  logic                         rsp_input_pending,
   output int                           error_count,
   output int                           waiting_count,
   output int                           checked_count,
   output int                           popped_count,
   output int                           dropped_count
);
   import sc2a_pkg::*;

   localparam int KEY_COUNT = 58;

   // Set-1 make codes 0x00..0x39 without and with shift held.
   localparam byte unsigned PLAIN_KEYS [KEY_COUNT] = '{
      8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
      "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
      "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60, 8'h00, 8'h5C,
      "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " "
   };
   localparam byte unsigned SHIFT_KEYS [KEY_COUNT] = '{
      8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
      "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
      "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|",
      "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " "
   };

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              ch_valid;
      logic              pending;
   } key_rsp_type;

   key_rsp_type       expected_rsps [$];
   logic              shift_held;
   logic              caps_on;
   logic [CHAR_W-1:0] char_ring [FIFO_DEPTH];
   int                wr_slot;
   int                rd_slot;
   int                n_errors  = 0;
   int                n_checked = 0;
   int                n_popped  = 0;
   int                n_dropped = 0;

   assign error_count   = n_errors;
   assign checked_count = n_checked;
   assign popped_count  = n_popped;
   assign dropped_count = n_dropped;

   // Looks up a make code and applies caps lock to lower-case letters.
   function automatic logic [CHAR_W-1:0] key_char(input logic [SCAN_W-1:0] sc,
                                                  input logic shifted, input logic caps);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_W'(shifted ? SHIFT_KEYS[sc] : PLAIN_KEYS[sc]);
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z && (caps ^ shifted))
         ch = ch - 7'd32;
      return ch;
   endfunction

   // Applies one request to the keyboard state and queues the response it should give.
   task automatic key_predict(input logic typ, input logic [SCAN_W-1:0] sc);
      key_rsp_type       r;
      logic [CHAR_W-1:0] ch;
      int                nxt;
      r = '0;
      if (typ == REQ_SCAN) begin
         if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE) begin
            shift_held = 1'b1;
         end else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK) begin
            shift_held = 1'b0;
         end else if (sc == SC_CAPS_MAKE) begin
            caps_on = ~caps_on;
         end else if (!sc[SCAN_W-1] && sc < KEY_COUNT) begin
            ch = key_char(sc, shift_held, caps_on);
            if (ch != '0) begin
               nxt = (wr_slot + 1) % FIFO_DEPTH;
               if (nxt != rd_slot) begin
                  char_ring[wr_slot] = ch;
                  wr_slot = nxt;
               end else begin
                  n_dropped++;
               end
            end
         end
      end else if (wr_slot != rd_slot) begin
         r.ch       = char_ring[rd_slot];
         r.ch_valid = 1'b1;
         rd_slot    = (rd_slot + 1) % FIFO_DEPTH;
      end
      r.pending = (wr_slot != rd_slot);
      expected_rsps.push_back(r);
   endtask

   // Both channels are sampled on the rising edge; the request side goes first so that
   // the order of expectations always matches the order of requests.
   always @(posedge clock) begin
      key_rsp_type want;
      if (reset) begin
         shift_held = 1'b0;
         caps_on    = 1'b0;
         wr_slot    = 0;
         rd_slot    = 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && !req_stall)
            key_predict(req_type, req_scan_code);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               n_errors++;
            end else begin
               want = expected_rsps.pop_front();
               n_checked++;
               if (rsp_char_valid) n_popped++;
               if (rsp_char_out !== want.ch) begin
                  $error("char_out expected %h actual %h", want.ch, rsp_char_out);
                  n_errors++;
               end
               if (rsp_char_valid !== want.ch_valid) begin
                  $error("char_valid expected %b actual %b", want.ch_valid, rsp_char_valid);
                  n_errors++;
               end
               if (rsp_input_pending !== want.pending) begin
                  $error("input_pending expected %b actual %b", want.pending,
                         rsp_input_pending);
                  n_errors++;
               end
            end
         end
      end
      waiting_count = expected_rsps.size();
   end

endmodule

// ===== dv/scancode_to_ascii_fifo_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the scancode-to-ASCII FIFO unit test: clock, reset, request stimulus and verdict.
// Depends on sc2a_pkg, the unit itself and scancode_to_ascii_fifo_unit_checker.
module scancode_to_ascii_fifo_unit_test;
   import sc2a_pkg::*;

   localparam int DEPTH       = FIFO_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int KEY_COUNT   = 58;

   // Scancodes used by name in the stimulus.
   localparam logic [SCAN_W-1:0] KEY_A     = 8'h1E;
   localparam logic [SCAN_W-1:0] KEY_Q     = 8'h10;
   localparam logic [SCAN_W-1:0] KEY_P     = 8'h19;
   localparam logic [SCAN_W-1:0] KEY_1     = 8'h02;
   localparam logic [SCAN_W-1:0] KEY_SPACE = 8'h39;
   localparam logic [SCAN_W-1:0] KEY_F1    = 8'h3B;
   localparam logic [SCAN_W-1:0] KEY_NONE  = 8'h00;
   localparam logic [SCAN_W-1:0] BREAK_BIT = 8'h80;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_type      = REQ_SCAN;
   logic [SCAN_W-1:0] req_scan_code = '0;
   logic              rsp_stall     = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [CHAR_W-1:0] rsp_char_out;
   logic              rsp_char_valid;
   logic              rsp_input_pending;

   int error_count;
   int waiting_count;
   int checked_count;
   int popped_count;
   int dropped_count;
   int sent_count  = 0;
   int cycle_count = 0;
   bit idle_on     = 1'b1;

   always #4 clock = ~clock;

   scancode_to_ascii_fifo_unit #(.FIFO_DEPTH(DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_scan_code     (req_scan_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_input_pending (rsp_input_pending)
   );

   scancode_to_ascii_fifo_unit_checker #(.FIFO_DEPTH(DEPTH)) char_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_scan_code     (req_scan_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_input_pending (rsp_input_pending),
      .error_count       (error_count),
      .waiting_count     (waiting_count),
      .checked_count     (checked_count),
      .popped_count      (popped_count),
      .dropped_count     (dropped_count)
   );

   // Hard stop in case the unit hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("scancode_to_ascii_fifo_unit_test NOT OK");
         $finish;
      end
   end

   // Response side stalls at random while idling is enabled.
   always @(negedge clock) begin
      rsp_stall <= !reset && idle_on && ($urandom_range(0, 99) < 26);
   end

   // Presents one request from a falling edge and returns at the falling edge after it
   // was taken. Valid is held between back-to-back requests.
   task automatic send_key(input logic typ, input logic [SCAN_W-1:0] sc);
      while (idle_on && $urandom_range(0, 99) < 26) begin
         req_valid     <= 1'b0;
         req_scan_code <= SCAN_W'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= typ;
      req_scan_code <= sc;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   // Holds off new requests until every outstanding response has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
   endtask

   initial begin
      int r;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty read, unmapped codes, shift, caps, both together, ignored breaks.
      send_key(REQ_READ, 8'hFF);
      send_key(REQ_SCAN, KEY_NONE);
      send_key(REQ_SCAN, KEY_A);
      send_key(REQ_READ, 8'h00);
      send_key(REQ_SCAN, SC_CAPS_MAKE);
      send_key(REQ_SCAN, KEY_A);
      send_key(REQ_SCAN, SC_LSHIFT_MAKE);
      send_key(REQ_SCAN, KEY_A);
      send_key(REQ_SCAN, KEY_1);
      send_key(REQ_SCAN, SC_LSHIFT_BREAK);
      send_key(REQ_SCAN, SC_CAPS_MAKE);
      send_key(REQ_SCAN, SC_RSHIFT_MAKE);
      send_key(REQ_SCAN, KEY_Q);
      send_key(REQ_SCAN, SC_RSHIFT_BREAK);
      send_key(REQ_SCAN, KEY_A | BREAK_BIT);
      send_key(REQ_SCAN, KEY_SPACE);
      send_key(REQ_SCAN, KEY_F1);
      send_key(REQ_SCAN, 8'h7F);
      send_key(REQ_SCAN, 8'hFF);
      send_key(REQ_SCAN, KEY_1);
      repeat (5) send_key(REQ_READ, SCAN_W'($urandom_range(0, 255)));

      // Random typing: mostly make codes with shift and caps traffic, some break
      // codes and noise, and reads about as often as characters are produced.
      for (int i = 0; i < 1200; i++) begin
         idle_on = !(i >= 400 && i < 600);
         if (i == 700)
            wait_drained();
         r = $urandom_range(0, 99);
         if (r < 40)
            send_key(REQ_SCAN, SCAN_W'($urandom_range(0, KEY_COUNT - 1)));
         else if (r < 48)
            send_key(REQ_SCAN, SCAN_W'($urandom_range(0, 127)) | BREAK_BIT);
         else if (r < 54)
            send_key(REQ_SCAN, $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
         else if (r < 60)
            send_key(REQ_SCAN, $urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
         else if (r < 63)
            send_key(REQ_SCAN, SC_CAPS_MAKE);
         else if (r < 68)
            send_key(REQ_SCAN, SCAN_W'($urandom_range(0, 255)));
         else
            send_key(REQ_READ, SCAN_W'($urandom_range(0, 255)));
      end
      idle_on = 1'b1;

      // Overflow the FIFO with letters, then drain it past empty.
      for (int i = 0; i < DEPTH + 44; i++)
         send_key(REQ_SCAN, SCAN_W'($urandom_range(KEY_Q, KEY_P)));
      for (int i = 0; i < DEPTH + 14; i++)
         send_key(REQ_READ, SCAN_W'($urandom_range(0, 255)));

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Sent %0d requests; checked %0d responses, %0d with a character popped.",
               sent_count, checked_count, popped_count);
      $display("Characters dropped on a full FIFO: %0d.", dropped_count);
      if (error_count == 0 && waiting_count == 0) begin
         $display("scancode_to_ascii_fifo_unit_test OK");
      end else begin
         $display("scancode_to_ascii_fifo_unit_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_xlate.sv
rtl/core/sc2a_mem.sv
rtl/core/scancode_to_ascii_fifo_unit.sv
dv/scancode_to_ascii_fifo_unit_checker.sv
dv/scancode_to_ascii_fifo_unit_test.sv
